// ===== hw/rtl/aise_pkg.sv =====
// Shared types, form selectors and fixed encoding patterns for the instruction encoder.
package aise_pkg;

    localparam logic [3:0] FUNC_MUL       = 4'd0;
    localparam logic [3:0] FUNC_DP_REG    = 4'd1;
    localparam logic [3:0] FUNC_DP_IMM    = 4'd2;
    localparam logic [3:0] FUNC_WIDE_MOVE = 4'd3;
    localparam logic [3:0] FUNC_LDR_LIT   = 4'd4;
    localparam logic [3:0] FUNC_REG_OFF   = 4'd5;
    localparam logic [3:0] FUNC_PRE_POST  = 4'd6;
    localparam logic [3:0] FUNC_UNS_OFF   = 4'd7;
    localparam logic [3:0] FUNC_B         = 4'd8;
    localparam logic [3:0] FUNC_BR        = 4'd9;
    localparam logic [3:0] FUNC_B_COND    = 4'd10;
    localparam logic [3:0] FUNC_NOP       = 4'd11;
    localparam logic [3:0] FUNC_WORD      = 4'd12;

    localparam logic [3:0] OPC_MSUB       = 4'd1;
    localparam logic [3:0] OPC_MOVN       = 4'd0;
    localparam logic [3:0] OPC_COND_NE    = 4'd1;
    localparam logic [3:0] COND_OFFSET    = 4'd8;

    localparam logic [31:0] ENC_MUL   = 32'h1B00_0000;
    localparam logic [31:0] ENC_DPR   = 32'h0A00_0000;
    localparam logic [31:0] ENC_DPI   = 32'h1100_0000;
    localparam logic [31:0] ENC_WIDE  = 32'h1280_0000;
    localparam logic [31:0] ENC_LIT   = 32'h1800_0000;
    localparam logic [31:0] ENC_SDT   = 32'hB800_0000;
    localparam logic [31:0] ENC_B     = 32'h1400_0000;
    localparam logic [31:0] ENC_BR    = 32'hD61F_0000;
    localparam logic [31:0] ENC_BCOND = 32'h5400_0000;
    localparam logic [31:0] ENC_NOP   = 32'hD503_201F;

    localparam logic [5:0] REG_OFF_OPTION = 6'b011010;
    localparam logic       ARITH_OPR_TOP  = 1'b1;

    typedef struct packed {
        logic [3:0]         func;
        logic               is_64;
        logic [3:0]         opcode;
        logic [4:0]         dest_reg;
        logic [4:0]         first_reg;
        logic [4:0]         second_reg;
        logic [4:0]         addend_reg;
        logic [1:0]         shift_kind;
        logic [5:0]         shift_amount;
        logic signed [31:0] immediate;
        logic               is_load;
        logic               pre_idx;
    } instr_t;

endpackage

// ===== hw/rtl/aise_encode.sv =====
// Combinational field packing of one decoded instruction into its machine word.
module aise_encode
    import aise_pkg::*;
(
    input  instr_t      instr,
    output logic [31:0] word
);

    logic [27:0] br_adj;
    logic [3:0]  cond_code;
    logic [1:0]  move_opc;

    // branch offsets: divide by four, rounding toward zero
    assign br_adj    = instr.immediate[27:0] + {26'b0, instr.immediate[31], instr.immediate[31]};
    assign cond_code = (instr.opcode > OPC_COND_NE) ? instr.opcode + COND_OFFSET : instr.opcode;
    assign move_opc  = (instr.opcode == OPC_MOVN) ? 2'b00 : instr.opcode[1:0] + 2'd1;

    always_comb begin
        word = '0;
        case (instr.func)
            FUNC_MUL: begin
                word        = ENC_MUL;
                word[31]    = instr.is_64;
                word[20:16] = instr.second_reg;
                word[15]    = (instr.opcode == OPC_MSUB);
                word[14:10] = instr.addend_reg;
                word[9:5]   = instr.first_reg;
                word[4:0]   = instr.dest_reg;
            end
            FUNC_DP_REG: begin
                word = ENC_DPR;
                if (!instr.opcode[3]) begin
                    word[30:29] = instr.opcode[2:1];
                    word[24:21] = {1'b0, instr.shift_kind, instr.opcode[0]};
                end else begin
                    word[30:29] = instr.opcode[1:0];
                    word[24:21] = {ARITH_OPR_TOP, instr.shift_kind, 1'b0};
                end
                word[31]    = instr.is_64;
                word[20:16] = instr.second_reg;
                word[15:10] = instr.shift_amount;
                word[9:5]   = instr.first_reg;
                word[4:0]   = instr.dest_reg;
            end
            FUNC_DP_IMM: begin
                word        = ENC_DPI;
                word[31]    = instr.is_64;
                word[30:29] = instr.opcode[1:0];
                word[22]    = (instr.shift_amount != 6'd0);
                word[21:10] = instr.immediate[11:0];
                word[9:5]   = instr.first_reg;
                word[4:0]   = instr.dest_reg;
            end
            FUNC_WIDE_MOVE: begin
                word        = ENC_WIDE;
                word[31]    = instr.is_64;
                word[30:29] = move_opc;
                word[22:21] = instr.shift_amount[5:4];
                word[20:5]  = instr.immediate[15:0];
                word[4:0]   = instr.dest_reg;
            end
            FUNC_LDR_LIT: begin
                word       = ENC_LIT;
                word[30]   = instr.is_64;
                word[23:5] = instr.immediate[18:0];
                word[4:0]  = instr.dest_reg;
            end
            FUNC_REG_OFF, FUNC_PRE_POST, FUNC_UNS_OFF: begin
                word     = ENC_SDT;
                word[30] = instr.is_64;
                word[24] = (instr.func == FUNC_UNS_OFF);
                word[22] = instr.is_load;
                if (instr.func == FUNC_REG_OFF) begin
                    word[21]    = 1'b1;
                    word[20:16] = instr.second_reg;
                    word[15:10] = REG_OFF_OPTION;
                end else if (instr.func == FUNC_PRE_POST) begin
                    word[21]    = 1'b0;
                    word[20:12] = instr.immediate[8:0];
                    word[11]    = instr.pre_idx;
                    word[10]    = 1'b1;
                end else begin
                    word[21:10] = instr.immediate[11:0];
                end
                word[9:5] = instr.first_reg;
                word[4:0] = instr.dest_reg;
            end
            FUNC_B: begin
                word       = ENC_B;
                word[25:0] = br_adj[27:2];
            end
            FUNC_BR: begin
                word      = ENC_BR;
                word[9:5] = instr.first_reg;
            end
            FUNC_B_COND: begin
                word       = ENC_BCOND;
                word[23:5] = br_adj[20:2];
                word[3:0]  = cond_code;
            end
            FUNC_NOP: begin
                word = ENC_NOP;
            end
            FUNC_WORD: begin
                word = instr.immediate;
            end
            default: begin
                word = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/arm64_subset_instruction_encoder_core.sv =====
// Top level: input register, instruction encoder and output register.
// One instruction is accepted per cycle while s_ready is high. Its machine word passes through
// both registers: the first register holds the decoded fields, the field-packing logic sits
// between the two registers, and the second register drives the result port. s_ready stays
// high unless both registers are full and m_ready is low, so full throughput holds as long
// as the result side takes one word per cycle.
module arm64_subset_instruction_encoder_core
    import aise_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_func,
    input  logic               s_is_64,
    input  logic [3:0]         s_opcode,
    input  logic [4:0]         s_dest_reg,
    input  logic [4:0]         s_first_reg,
    input  logic [4:0]         s_second_reg,
    input  logic [4:0]         s_addend_reg,
    input  logic [1:0]         s_shift_kind,
    input  logic [5:0]         s_shift_amount,
    input  logic signed [31:0] s_immediate,
    input  logic               s_is_load,
    input  logic               s_pre_idx,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_machine_word
);

    instr_t      instr_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] enc_word;
    logic        out_ready;
    logic        in_take;

    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;
    assign in_take   = s_valid && s_ready;

    assign in_valid_next  = in_take || (in_valid_reg && !out_ready);
    assign out_valid_next = (in_valid_reg && out_ready) || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            instr_reg.func         <= s_func;
            instr_reg.is_64        <= s_is_64;
            instr_reg.opcode       <= s_opcode;
            instr_reg.dest_reg     <= s_dest_reg;
            instr_reg.first_reg    <= s_first_reg;
            instr_reg.second_reg   <= s_second_reg;
            instr_reg.addend_reg   <= s_addend_reg;
            instr_reg.shift_kind   <= s_shift_kind;
            instr_reg.shift_amount <= s_shift_amount;
            instr_reg.immediate    <= s_immediate;
            instr_reg.is_load      <= s_is_load;
            instr_reg.pre_idx      <= s_pre_idx;
        end
        if (in_valid_reg && out_ready) begin
            word_reg <= enc_word;
        end
    end

    aise_encode u_encode (
        .instr (instr_reg),
        .word  (enc_word)
    );

    assign m_valid        = out_valid_reg;
    assign m_machine_word = word_reg;

endmodule

// ===== hw/rtl/aise_checker.sv =====
// Port-level checks on the encoder core, bound to the top level.
module aise_checker
    import aise_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [3:0]  s_func,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_machine_word
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_machine_word))
        else $error("stalled result transaction changed");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while result side free");

    a_nop_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func == FUNC_NOP) ##1 m_ready
        |=> m_valid && m_machine_word == ENC_NOP)
        else $error("nop transaction gave wrong word");

endmodule

bind arm64_subset_instruction_encoder_core aise_checker u_aise_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_func         (s_func),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_machine_word (m_machine_word)
);
